// File: hdl/tcw_pkg.sv
// tcw_pkg: sizes, codes and the controller/datapath command and status
// structs shared by the text console writer. No dependencies.
package tcw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = ROWS * COLUMNS;

  localparam int unsigned CELL_AW = 11;   // cell_address width
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned WORD_W  = CHAR_W + COLOR_W;

  localparam logic              OP_PUT       = 1'b0;
  localparam logic              OP_READ      = 1'b1;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd15;

  // register indexes on the configuration port
  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef struct packed {
    logic load_item;     // capture the accepted request
    logic clear_en;      // one step of the clearing pass
    logic scroll_en;     // one step of the scroll copy
    logic read_en;       // read the requested cell
    logic line_break;    // cursor to the start of the next row
    logic scroll_cursor; // cursor to the start of the bottom row, flag scroll
    logic put_write;     // write the character at the cursor
    logic out_load;      // load the result register
  } tcw_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_newline;
    logic wrap_due;
    logic at_bottom;
    logic sweep_last;
    logic out_free;
  } tcw_sts_t;

endpackage

// File: hdl/tcw_in_if.sv
// tcw_in_if: request channel of the text console writer.
// Depends on tcw_pkg.
interface tcw_in_if;
  import tcw_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [CHAR_W-1:0]  char_code;
  logic [CELL_AW-1:0] cell_address;

  modport source (output valid, output opcode, output char_code, output cell_address,
                  input ready);
  modport sink   (input valid, input opcode, input char_code, input cell_address,
                  output ready);
endinterface

// File: hdl/tcw_out_if.sv
// tcw_out_if: result channel of the text console writer.
// Depends on tcw_pkg.
interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] cell_word;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic              scrolled;

  modport source (output valid, output cell_word, output cursor_row, output cursor_col,
                  output scrolled, input ready);
  modport sink   (input valid, input cell_word, input cursor_row, input cursor_col,
                  input scrolled, output ready);
endinterface

// File: hdl/tcw_ctrl.sv
// tcw_ctrl: sequencer for the text console writer; drives the datapath
// through tcw_cmd_t and watches tcw_sts_t. Depends on tcw_pkg.
module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t cmd_o
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_WRITE  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.is_read) begin
          cmd_o.read_en = 1'b1;
          state_d       = S_READ;
        end else if (sts_i.is_newline || sts_i.wrap_due) begin
          if (sts_i.at_bottom) begin
            cmd_o.scroll_cursor = 1'b1;
            state_d             = S_SCROLL;
          end else begin
            cmd_o.line_break = 1'b1;
            state_d          = sts_i.is_newline ? S_DONE : S_WRITE;
          end
        end else begin
          state_d = S_WRITE;
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_SCROLL: begin
        cmd_o.scroll_en = 1'b1;
        if (sts_i.sweep_last) state_d = S_DRAIN;
      end
      // last copied row word still being written back
      S_DRAIN: begin
        state_d = sts_i.is_newline ? S_DONE : S_WRITE;
      end
      S_WRITE: begin
        cmd_o.put_write = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule

// File: hdl/tcw_dp.sv
// tcw_dp: cell store, cursor, sweep counter and result register of the
// text console writer. Depends on tcw_pkg.
module tcw_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcw_pkg::tcw_cmd_t          cmd_i,
  output tcw_pkg::tcw_sts_t          sts_o,
  input  logic [tcw_pkg::COLOR_W-1:0] text_color_i,
  input  logic                       opcode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcw_pkg::CELL_AW-1:0] cell_address_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [tcw_pkg::WORD_W-1:0]  cell_word_o,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col_o,
  output logic                       scrolled_o
);
  import tcw_pkg::*;

  localparam logic [CELL_AW-1:0] LAST_CELL  = CELL_AW'(CELLS - 1);
  localparam logic [CELL_AW-1:0] BLANK_BASE = CELL_AW'(CELLS - COLUMNS);

  logic [WORD_W-1:0] mem [CELLS];
  logic [WORD_W-1:0] rdata_q;

  logic               item_op_q;
  logic [CHAR_W-1:0]  item_char_q;
  logic [CELL_AW-1:0] item_addr_q;

  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic               scrolled_q;

  logic [CELL_AW-1:0] sweep_q;
  logic               pend_q;
  logic               pend_blank_q;
  logic [CELL_AW-1:0] pend_addr_q;

  logic               out_valid_q;
  logic [WORD_W-1:0]  out_word_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [COL_W-1:0]   out_col_q;
  logic               out_scr_q;

  logic               we, re, in_range, sweep_blank;
  logic [CELL_AW-1:0] wa, ra, cursor_addr;
  logic [WORD_W-1:0]  wd;

  assign in_range    = (item_addr_q < CELL_AW'(CELLS));
  assign sweep_blank = (sweep_q >= BLANK_BASE);
  assign cursor_addr = CELL_AW'(row_q * CELL_AW'(COLUMNS)) + CELL_AW'(col_q);

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_op_q   <= opcode_i;
      item_char_q <= char_code_i;
      item_addr_q <= cell_address_i;
    end
  end

  // one write port: clearing, delayed scroll write-back, or a put
  always_comb begin
    we = 1'b0;
    wa = sweep_q;
    wd = {RESET_COLOR, SPACE_CODE};
    priority if (cmd_i.clear_en) begin
      we = 1'b1;
    end else if (pend_q) begin
      we = 1'b1;
      wa = pend_addr_q;
      wd = pend_blank_q ? {text_color_i, SPACE_CODE} : rdata_q;
    end else if (cmd_i.put_write) begin
      we = 1'b1;
      wa = cursor_addr;
      wd = {text_color_i, item_char_q};
    end
  end

  always_comb begin
    re = 1'b0;
    ra = item_addr_q;
    if (cmd_i.scroll_en && !sweep_blank) begin
      re = 1'b1;
      ra = sweep_q + CELL_AW'(COLUMNS);
    end else if (cmd_i.read_en && in_range) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_q <= mem[ra];
  end

  // sweep counter shared by the clearing pass and the scroll copy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q      <= '0;
      pend_q       <= 1'b0;
      pend_blank_q <= 1'b0;
      pend_addr_q  <= '0;
    end else begin
      if (cmd_i.clear_en || cmd_i.scroll_en) begin
        sweep_q <= (sweep_q == LAST_CELL) ? '0 : sweep_q + 1'b1;
      end
      pend_q       <= cmd_i.scroll_en;
      pend_blank_q <= sweep_blank;
      pend_addr_q  <= sweep_q;
    end
  end

  // cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      scrolled_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) scrolled_q <= 1'b0;
      if (cmd_i.line_break) begin
        row_q <= row_q + 1'b1;
        col_q <= '0;
      end
      if (cmd_i.scroll_cursor) begin
        col_q      <= '0;
        scrolled_q <= 1'b1;
      end
      if (cmd_i.put_write) col_q <= col_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q <= (item_op_q == OP_READ && in_range) ? rdata_q : '0;
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_scr_q  <= scrolled_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_word_o  = out_word_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign scrolled_o   = out_scr_q;

  assign sts_o.is_read    = (item_op_q == OP_READ);
  assign sts_o.is_newline = (item_char_q == NEWLINE_CODE);
  assign sts_o.wrap_due   = (col_q == COL_W'(COLUMNS));
  assign sts_o.at_bottom  = (row_q == ROW_W'(ROWS - 1));
  assign sts_o.sweep_last = (sweep_q == LAST_CELL);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// File: hdl/text_console_writer.sv
// text_console_writer: top level; holds the APB register, joins the
// controller (tcw_ctrl) and datapath (tcw_dp). Depends on tcw_pkg, tcw_in_if, tcw_out_if.

// An 80 by 25 text console cell store with a put/read request channel and one
// result per request. After reset a clearing pass writes a space in colour 15
// to all 2000 cells, one cell a cycle, so no request is taken until the pass
// ends (register writes are taken). A request that scrolls runs a copy pass
// in which every cell of the store goes through its single write port once
// and every cell below the top row through its single read port once. The
// result register lets the next request be accepted and worked on while the
// previous result waits. text_color sits at byte address 0 and applies to
// characters written and rows blanked afterward.
module text_console_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tcw_in_if.sink      in_i,
  tcw_out_if.source   out_o
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] text_color_q;
  tcw_cmd_t           cmd;
  tcw_sts_t           sts;
  logic               reg_hit;

  assign reg_hit = (paddr[2] == REG_TEXT_COLOR);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? 32'(text_color_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= RESET_COLOR;
    end else if (psel && penable && pwrite && reg_hit) begin
      text_color_q <= pwdata[COLOR_W-1:0];
    end
  end

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .text_color_i   (text_color_q),
    .opcode_i       (in_i.opcode),
    .char_code_i    (in_i.char_code),
    .cell_address_i (in_i.cell_address),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .cell_word_o    (out_o.cell_word),
    .cursor_row_o   (out_o.cursor_row),
    .cursor_col_o   (out_o.cursor_col),
    .scrolled_o     (out_o.scrolled)
  );

endmodule

// File: dv/tb_text_console_writer.sv
// tb_text_console_writer: self-checking testbench for the text console writer.
// Drives put/read requests and the text_color register and checks every result
// against a screen predictor. Depends on tcw_pkg, tcw_in_if, tcw_out_if.
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] cell_word;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
  } reply_t;

  // screen predictor plus the queue of replies still owed by the block
  class screen_scoreboard;
    logic [WORD_W-1:0]  cells[CELLS];
    int unsigned        row;
    int unsigned        col;
    logic [COLOR_W-1:0] color;
    reply_t             awaited[$];
    int unsigned        mismatches, puts, reads, scrolls, wraps, checked;

    function new();
      color = RESET_COLOR;
      foreach (cells[i]) cells[i] = {RESET_COLOR, SPACE_CODE};
      row = 0;
      col = 0;
    endfunction

    // returns 1 when the screen scrolled
    function bit line_feed();
      col = 0;
      if (row + 1 < ROWS) begin
        row++;
        return 1'b0;
      end
      for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      for (int x = 0; x < COLUMNS; x++) cells[(ROWS - 1) * COLUMNS + x] = {color, SPACE_CODE};
      row = ROWS - 1;
      scrolls++;
      return 1'b1;
    endfunction

    function void note_request(logic op, logic [CHAR_W-1:0] ch, logic [CELL_AW-1:0] addr);
      reply_t r;
      r = '0;
      if (op == OP_READ) begin
        reads++;
        if (addr < CELLS) r.cell_word = cells[addr];
      end else if (ch == NEWLINE_CODE) begin
        puts++;
        r.scrolled = line_feed();
      end else begin
        puts++;
        // deferred wrap: the break happens only when the next glyph arrives
        if (col >= COLUMNS) begin
          wraps++;
          r.scrolled = line_feed();
        end
        cells[row * COLUMNS + col] = {color, ch};
        col++;
      end
      r.cursor_row = ROW_W'(row);
      r.cursor_col = COL_W'(col);
      awaited.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.cell_word !== want.cell_word) begin
        $error("cell_word: expected %h, got %h", want.cell_word, got.cell_word);
        mismatches++;
      end
      if (got.cursor_row !== want.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
        mismatches++;
      end
      if (got.cursor_col !== want.cursor_col) begin
        $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
        mismatches++;
      end
      if (got.scrolled !== want.scrolled) begin
        $error("scrolled: expected %0b, got %0b", want.scrolled, got.scrolled);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tcw_in_if  req_bus ();
  tcw_out_if rsp_bus ();

  text_console_writer DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (req_bus),
    .out_o   (rsp_bus)
  );

  screen_scoreboard sb;
  int unsigned      snd_idle_pct;
  int unsigned      rcv_stall_pct;
  int unsigned      items_sent;
  int unsigned      color_settings;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side: check accepted results, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready)
      sb.check_reply('{rsp_bus.cell_word, rsp_bus.cursor_row, rsp_bus.cursor_col,
                       rsp_bus.scrolled});
    rsp_bus.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  task automatic send_request(input logic op, input logic [CHAR_W-1:0] ch,
                              input logic [CELL_AW-1:0] addr);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.opcode       <= op;
    req_bus.char_code    <= ch;
    req_bus.cell_address <= addr;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    sb.note_request(op, ch, addr);
    items_sent++;
  endtask

  function automatic logic [CHAR_W-1:0] rand_glyph();
    logic [CHAR_W-1:0] g;
    g = CHAR_W'($urandom_range(0, 255));
    if (g == NEWLINE_CODE) g = CHAR_W'($urandom_range(11, 255));
    return g;
  endfunction

  function automatic logic [CELL_AW-1:0] rand_addr();
    if ($urandom_range(0, 99) < 85) return CELL_AW'($urandom_range(0, CELLS - 1));
    return CELL_AW'($urandom_range(0, 2047));
  endfunction

  task automatic put_glyph(input logic [CHAR_W-1:0] ch);
    send_request(OP_PUT, ch, CELL_AW'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [CELL_AW-1:0] addr);
    send_request(OP_READ, CHAR_W'($urandom_range(0, 255)), addr);
  endtask

  // one random sequence; mostly text lines, line fills and reads
  task automatic random_burst();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      n = $urandom_range(1, 40);
      repeat (n) put_glyph(rand_glyph());
      if ($urandom_range(0, 99) < 30) put_glyph(NEWLINE_CODE);
    end else if (pick < 52) begin
      // fill a whole line so the cursor sits on the pending-wrap column
      put_glyph(NEWLINE_CODE);
      repeat (COLUMNS) put_glyph(rand_glyph());
      if ($urandom_range(0, 1)) put_glyph(NEWLINE_CODE);
      else put_glyph(rand_glyph());
    end else if (pick < 62) begin
      n = $urandom_range(1, 6);
      repeat (n) put_glyph(NEWLINE_CODE);
    end else if (pick < 92) begin
      n = $urandom_range(1, 12);
      repeat (n) read_cell(rand_addr());
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) send_request(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                              CELL_AW'($urandom_range(0, 2047)));
    end
  endtask

  // wait until every request has its result, then let the pipeline settle
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_text_color(input logic [COLOR_W-1:0] hue);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_TEXT_COLOR);
    pwdata  <= {24'd0, hue};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.color = hue;
    color_settings++;
  endtask

  initial begin : stimulus
    int unsigned        target;
    int unsigned        fails;
    logic [COLOR_W-1:0] hue;
    sb = new();
    items_sent     = 0;
    color_settings = 1;
    snd_idle_pct   = 0;
    rcv_stall_pct  = 0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_bus.valid        <= 1'b0;
    req_bus.opcode       <= OP_PUT;
    req_bus.char_code    <= '0;
    req_bus.cell_address <= '0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // directed: reset contents, address extremes, byte extremes, newline neighbors
    read_cell(CELL_AW'(0));
    read_cell(CELL_AW'(CELLS - 1));
    read_cell(CELL_AW'(CELLS));
    send_request(OP_READ, 8'hFF, 11'h7FF);
    send_request(OP_PUT, 8'h00, 11'h7FF);
    send_request(OP_PUT, 8'hFF, 11'h000);
    put_glyph(NEWLINE_CODE);
    put_glyph(CHAR_W'(NEWLINE_CODE - 1));
    put_glyph(CHAR_W'(NEWLINE_CODE + 1));
    put_glyph(SPACE_CODE);
    put_glyph(8'h41);
    read_cell(CELL_AW'(0));
    read_cell(CELL_AW'(1));
    read_cell(CELL_AW'(2));
    read_cell(CELL_AW'(COLUMNS));
    read_cell(CELL_AW'(COLUMNS + 2));
    read_cell(CELL_AW'(COLUMNS + 4));
    put_glyph(NEWLINE_CODE);
    read_cell(CELL_AW'(2 * COLUMNS));

    for (int p = 0; p < 8; p++) begin
      drain();
      hue = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom_range(0, 255));
      write_text_color(hue);
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 48; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 48; end
        default: begin snd_idle_pct = 12; rcv_stall_pct = 12; end
      endcase
      target = items_sent + 1850 / 8;
      while (items_sent < target) random_burst();
    end

    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    drain();
    repeat (10) @(posedge clk_i);

    fails = sb.mismatches + sb.awaited.size();
    $display("run covered %0d puts (%0d scrolls, %0d deferred wraps) and %0d reads",
             sb.puts, sb.scrolls, sb.wraps, sb.reads);
    $display("%0d results checked across %0d colour settings", sb.checked, color_settings);
    if (fails == 0) begin
      $display("text_console_writer verification clean");
    end else begin
      $display("text_console_writer verification failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("text_console_writer verification failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/tcw_pkg.sv
hdl/tcw_in_if.sv
hdl/tcw_out_if.sv
hdl/tcw_ctrl.sv
hdl/tcw_dp.sv
hdl/text_console_writer.sv
dv/tb_text_console_writer.sv
